FILE: src/mwo_pkg.sv
package mwo_pkg;

   localparam int REQ_W = 176;
   localparam int RSP_W = 224;
   localparam int MUL_STEPS = 64;
   localparam int DIV_STEPS = 96;

   localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
   localparam logic [1:0] REG_TICKS_PER_REV = 2'd1;
   localparam logic [1:0] REG_HALF_BASE_SUM = 2'd2;

   localparam logic [41:0] PI_Q = 42'h3243F6A8886;
   localparam logic [33:0] CORDIC_GAIN = 34'h026DD3B6A;
   localparam logic [19:0] SCALE_LIN = 20'd1000000;
   localparam logic [19:0] SCALE_ANG = 20'd1000;

   // Datapath operations in the order the controller runs them.
   typedef enum logic [4:0] {
      OP_MUL_LR, OP_MUL_LPI, OP_DIV_L,
      OP_MUL_TR, OP_MUL_TPI, OP_DIV_T,
      OP_MUL_AR, OP_DIV_A,
      OP_MUL_VL, OP_DIV_VL, OP_MUL_VT, OP_DIV_VT, OP_MUL_VA, OP_DIV_VA,
      OP_MUL_XC, OP_MUL_XS, OP_MUL_YS, OP_MUL_YC
   } op_type;

   localparam op_type OP_LAST = OP_MUL_YC;

   typedef struct packed {
      logic   load;
      logic   store_first;
      logic   prep;
      logic   start;
      op_type op;
      logic   commit;
   } mwo_cmd_type;

   typedef struct packed {
      logic first;
      logic stale;
      logic unit_done;
   } mwo_status_type;

   function automatic logic is_div(input op_type op);
      return op inside {OP_DIV_L, OP_DIV_T, OP_DIV_A, OP_DIV_VL, OP_DIV_VT, OP_DIV_VA};
   endfunction

   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'h20000000;
         5'd1: v = 32'h12E4051E;
         5'd2: v = 32'h09FB385B;
         5'd3: v = 32'h051111D4;
         5'd4: v = 32'h028B0D43;
         5'd5: v = 32'h0145D7E1;
         5'd6: v = 32'h00A2F61E;
         5'd7: v = 32'h00517C55;
         5'd8: v = 32'h0028BE53;
         5'd9: v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

FILE: src/mwo_mul.sv
module mwo_mul import mwo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);

   logic [127:0] p_ff, p_in;
   logic [63:0]  a_ff, a_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [64:0]  sum;

   // Shift-add: one multiplier bit per cycle, high half accumulates.
   always_comb begin
      p_in = p_ff;
      a_in = a_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum = {1'b0, p_ff[127:64]} + (p_ff[0] ? {1'b0, a_ff} : 65'd0);
      if (start) begin
         p_in = {64'd0, b};
         a_in = a;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in = {sum, p_ff[63:1]};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      p_ff <= p_in;
      a_ff <= a_in;
   end

   assign done = done_ff;
   assign prod = p_ff;

endmodule

FILE: src/mwo_div.sv
module mwo_div import mwo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [95:0] n,
   input  logic [63:0] d,
   output logic        done,
   output logic [95:0] quo
);

   logic [95:0] nq_ff, nq_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;

   // Restoring division, one quotient bit per cycle shifted in behind the dividend.
   always_comb begin
      nq_in = nq_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, nq_ff[95]};
      diff = trial - {1'b0, d_ff};
      ge = (trial >= {1'b0, d_ff});
      if (start) begin
         nq_in = n;
         rem_in = '0;
         d_in = d;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : trial[63:0];
         nq_in = {nq_ff[94:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      nq_ff <= nq_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quo = nq_ff;

endmodule

FILE: src/mwo_cordic.sv
module mwo_cordic import mwo_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);

   localparam int CW = $clog2(CORDIC_STEPS + 1);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] xs, ys, at;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               flip_ff, flip_in;
   logic               flip;
   logic [31:0]        a_adj;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      // Angles in the second and third quarter turn are rotated by a half turn.
      flip = angle[31] ^ angle[30];
      a_adj = angle + (flip ? 32'h80000000 : 32'h0);
      xs = x_ff >>> 5'(cnt_ff);
      ys = y_ff >>> 5'(cnt_ff);
      at = signed'({2'b00, atan_lut(5'(cnt_ff))});
      if (start) begin
         x_in = signed'(CORDIC_GAIN);
         y_in = '0;
         z_in = 34'(signed'(a_adj));
         cnt_in = '0;
         busy_in = 1'b1;
         flip_in = flip;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
   end

   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

FILE: src/mwo_ctrl.sv
module mwo_ctrl import mwo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  mwo_status_type status,
   output mwo_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_ISSUE  = 5'b00100,
      ST_WAIT   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd = '0;
      cmd.op = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.first) begin
               cmd.store_first = 1'b1;
               state_in = ST_IDLE;
            end else if (status.stale) begin
               state_in = ST_IDLE;
            end else begin
               cmd.prep = 1'b1;
               op_in = OP_MUL_LR;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.unit_done) begin
               if (op_ff == OP_LAST) begin
                  state_in = ST_FINISH;
               end else begin
                  op_in = op_type'(5'(op_ff + 5'd1));
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            // The previous word must have left the output register.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_MUL_LR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: src/mwo_dpath.sv
module mwo_dpath import mwo_pkg::*; #(
   parameter int TICK_BITS = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  mwo_cmd_type      cmd,
   output mwo_status_type   status,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [19:0] radius_ff;
   logic [15:0] tpr_ff;
   logic [23:0] lsum_ff;

   logic [3:0][31:0] in_ticks_ff;
   logic [47:0]      in_time_ff;

   logic             started_ff;
   logic [3:0][31:0] last_ticks_ff;
   logic [47:0]      last_time_ff;
   logic [47:0]      pose_x_ff, pose_y_ff, pose_x_in, pose_y_in;
   logic [31:0]      heading_ff, heading_in;

   logic [33:0] sl_mag_ff, st_mag_ff, sa_mag_ff;
   logic        sl_neg_ff, st_neg_ff, sa_neg_ff;
   logic [47:0] dt_ff;
   logic [39:0] tl_ff;

   op_type      op_ff;
   logic [95:0] ml_ff, mt_ff, ma_ff;
   logic [31:0] vel_l_ff, vel_t_ff, vel_a_ff;
   logic [79:0] acc_x_ff, acc_y_ff;

   logic [47:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic [31:0] rsp_heading_ff, rsp_vel_l_ff, rsp_vel_t_ff, rsp_vel_a_ff;

   logic [3:0][31:0]   diff;
   logic signed [34:0] dext [4];
   logic signed [34:0] sl, st, sa;
   logic [15:0]        tpr_fix;
   logic [23:0]        lsum_fix;
   logic [31:0]        ang;

   logic signed [33:0] c_val, s_val;
   logic [33:0]        c_mag, s_mag;

   logic          mul_start, div_start, mul_done, div_done;
   logic [63:0]   mul_a, mul_b, div_d;
   logic [95:0]   div_n, quo;
   logic [127:0]  prod;

   function automatic logic [79:0] signed_term(input logic neg, input logic [127:0] p);
      return neg ? -p[79:0] : p[79:0];
   endfunction

   function automatic logic [31:0] sat_vel(input logic neg, input logic ovf,
                                           input logic [95:0] q);
      logic [31:0] v;
      if (ovf) begin
         v = neg ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (neg) begin
         v = (q > 96'h80000000) ? 32'h80000000 : -q[31:0];
      end else begin
         v = (q > 96'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
      return v;
   endfunction

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         diff[k] = in_ticks_ff[k] - last_ticks_ff[k];
         dext[k] = 35'(signed'(diff[k][TICK_BITS-1:0]));
      end
      sl = dext[0] + dext[1] + dext[2] + dext[3];
      st = -dext[0] + dext[1] + dext[2] - dext[3];
      sa = -dext[0] + dext[1] - dext[2] + dext[3];
   end

   assign tpr_fix = (tpr_ff == '0) ? 16'd1 : tpr_ff;
   assign lsum_fix = (lsum_ff == '0) ? 24'd1 : lsum_ff;

   assign status.first = ~started_ff;
   assign status.stale = (in_time_ff <= last_time_ff);
   assign status.unit_done = mul_done | div_done;

   assign c_mag = c_val[33] ? 34'(-c_val) : 34'(c_val);
   assign s_mag = s_val[33] ? 34'(-s_val) : 34'(s_val);

   assign mul_start = cmd.start & ~is_div(cmd.op);
   assign div_start = cmd.start & is_div(cmd.op);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_LR:  begin mul_a = 64'(sl_mag_ff);  mul_b = 64'(radius_ff); end
         OP_MUL_LPI: begin mul_a = prod[63:0];     mul_b = 64'(PI_Q); end
         OP_MUL_TR:  begin mul_a = 64'(st_mag_ff);  mul_b = 64'(radius_ff); end
         OP_MUL_TPI: begin mul_a = prod[63:0];     mul_b = 64'(PI_Q); end
         OP_MUL_AR:  begin mul_a = 64'(sa_mag_ff);  mul_b = 64'(radius_ff); end
         OP_MUL_VL:  begin mul_a = ml_ff[63:0];    mul_b = 64'(SCALE_LIN); end
         OP_MUL_VT:  begin mul_a = mt_ff[63:0];    mul_b = 64'(SCALE_LIN); end
         OP_MUL_VA:  begin mul_a = ma_ff[63:0];    mul_b = 64'(SCALE_ANG); end
         OP_MUL_XC:  begin mul_a = ml_ff[63:0];    mul_b = 64'(c_mag); end
         OP_MUL_XS:  begin mul_a = mt_ff[63:0];    mul_b = 64'(s_mag); end
         OP_MUL_YS:  begin mul_a = ml_ff[63:0];    mul_b = 64'(s_mag); end
         OP_MUL_YC:  begin mul_a = mt_ff[63:0];    mul_b = 64'(c_mag); end
         default: ;
      endcase
   end

   // Every division rounds half away from zero by adding half the divisor first.
   always_comb begin
      div_n = '0;
      div_d = 64'd1;
      case (cmd.op)
         OP_DIV_L, OP_DIV_T: begin
            div_n = prod[95:0] + 96'({tpr_fix, 40'd0});
            div_d = 64'({tpr_fix, 41'd0});
         end
         OP_DIV_A: begin
            div_n = {prod[65:0], 30'd0} + 96'(tl_ff[39:1]);
            div_d = 64'(tl_ff);
         end
         OP_DIV_VL, OP_DIV_VT, OP_DIV_VA: begin
            div_n = prod[95:0] + 96'(dt_ff[47:1]);
            div_d = 64'(dt_ff);
         end
         default: ;
      endcase
   end

   assign ang = sa_neg_ff ? -ma_ff[31:0] : ma_ff[31:0];
   assign pose_x_in = pose_x_ff + acc_x_ff[77:30];
   assign pose_y_in = pose_y_ff + acc_y_ff[77:30];
   assign heading_in = heading_ff + ang;

   mwo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   mwo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .n     (div_n),
      .d     (div_d),
      .done  (div_done),
      .quo   (quo)
   );

   mwo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.prep),
      .angle   (heading_ff),
      .cos_out (c_val),
      .sin_out (s_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 20'd50000;
         tpr_ff <= 16'd1024;
         lsum_ff <= 24'd300000;
         started_ff <= 1'b0;
         last_ticks_ff <= '0;
         last_time_ff <= '0;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         heading_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_WHEEL_RADIUS:  radius_ff <= csr_wdata[19:0];
               REG_TICKS_PER_REV: tpr_ff <= csr_wdata[15:0];
               REG_HALF_BASE_SUM: lsum_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.store_first) begin
            started_ff <= 1'b1;
            last_ticks_ff <= in_ticks_ff;
            last_time_ff <= in_time_ff;
         end
         if (cmd.commit) begin
            last_ticks_ff <= in_ticks_ff;
            last_time_ff <= in_time_ff;
            pose_x_ff <= pose_x_in;
            pose_y_ff <= pose_y_in;
            heading_ff <= heading_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ticks_ff <= req_tdata[127:0];
         in_time_ff <= req_tdata[175:128];
      end
      if (cmd.prep) begin
         sl_neg_ff <= sl[34];
         st_neg_ff <= st[34];
         sa_neg_ff <= sa[34];
         sl_mag_ff <= sl[34] ? 34'(-sl) : sl[33:0];
         st_mag_ff <= st[34] ? 34'(-st) : st[33:0];
         sa_mag_ff <= sa[34] ? 34'(-sa) : sa[33:0];
         dt_ff <= in_time_ff - last_time_ff;
         tl_ff <= 40'(tpr_fix) * 40'(lsum_fix);
      end
      if (cmd.start) begin
         op_ff <= cmd.op;
      end
      if (div_done) begin
         case (op_ff)
            OP_DIV_L:  ml_ff <= quo;
            OP_DIV_T:  mt_ff <= quo;
            OP_DIV_A:  ma_ff <= quo;
            OP_DIV_VL: vel_l_ff <= sat_vel(sl_neg_ff, |ml_ff[95:64], quo);
            OP_DIV_VT: vel_t_ff <= sat_vel(st_neg_ff, |mt_ff[95:64], quo);
            OP_DIV_VA: vel_a_ff <= sat_vel(sa_neg_ff, |ma_ff[95:64], quo);
            default: ;
         endcase
      end
      // Rotation terms; the rounding half is folded in with the first term.
      if (mul_done) begin
         case (op_ff)
            OP_MUL_XC:
               acc_x_ff <= signed_term(sl_neg_ff ^ c_val[33], prod) + 80'h20000000;
            OP_MUL_XS:
               acc_x_ff <= acc_x_ff + signed_term(~st_neg_ff ^ s_val[33], prod);
            OP_MUL_YS:
               acc_y_ff <= signed_term(sl_neg_ff ^ s_val[33], prod) + 80'h20000000;
            OP_MUL_YC:
               acc_y_ff <= acc_y_ff + signed_term(st_neg_ff ^ c_val[33], prod);
            default: ;
         endcase
      end
      if (cmd.commit) begin
         rsp_pos_x_ff <= pose_x_in;
         rsp_pos_y_ff <= pose_y_in;
         rsp_heading_ff <= heading_in;
         rsp_vel_l_ff <= vel_l_ff;
         rsp_vel_t_ff <= vel_t_ff;
         rsp_vel_a_ff <= vel_a_ff;
      end
   end

   assign rsp_tdata = {rsp_vel_a_ff, rsp_vel_t_ff, rsp_vel_l_ff,
                       rsp_heading_ff, rsp_pos_y_ff, rsp_pos_x_ff};

endmodule

FILE: src/mecanum_wheel_odometry.sv
// A sample that produces a result goes from acceptance to the result word through the check
// state, twelve serial multiplies and six serial divides, then waits for a free output register.
// The first sample and a sample with a stale time go back to idle from the check state.
// The next sample is accepted once the block is back in idle, even while a result still waits.
// Reset is synchronous and active high; it clears the pose, the stored sample and the
// registers to their defaults (radius 50000 um, 1024 ticks per turn, 300000 um base sum).
module mecanum_wheel_odometry import mwo_pkg::*; #(
   parameter int TICK_BITS = 32,
   parameter int CORDIC_STEPS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // ticks_wheel0, ticks_wheel1, ticks_wheel2, ticks_wheel3, time_us
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pos_x_um, pos_y_um, heading, vel_long_um_s, vel_trans_um_s, vel_ang
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata
);

   mwo_cmd_type    cmd;
   mwo_status_type status;

   mwo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mwo_dpath #(
      .TICK_BITS    (TICK_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
